// ===== rtl/core/start_length_end_frame_parser_macros.svh =====
// Assertion macros shared by the frame parser RTL.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef START_LENGTH_END_FRAME_PARSER_MACROS_SVH
`define START_LENGTH_END_FRAME_PARSER_MACROS_SVH

// same-cycle implication, disabled in reset
`define SLEF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slef assertion failed");

// next-cycle implication, disabled in reset
`define SLEF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slef assertion failed");

`endif

// ===== rtl/core/slef_pkg.sv =====
// Package for the start/length/end frame parser: codes, constants, result type.
// No dependencies.
package slef_pkg;

    localparam logic [7:0]  START_MARK      = 8'h0A;
    localparam logic [7:0]  END_MARK        = 8'hA0;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4096;

    localparam int unsigned PADDR_W = 2;
    localparam logic [PADDR_W-1:0] ADDR_MAX_PAYLOAD = '0;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_END     = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_END     = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_START = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_BAD_END   = 2'd3
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic        last_payload;
        status_t     status;
        logic [15:0] frame_length;
    } slef_res_t;

endpackage

// ===== rtl/core/start_length_end_frame_parser.sv =====
// Start/length/end frame parser: link bytes in, payload / frame-end / error results out.
// Depends on slef_pkg, slef_cfg, slef_parse, slef_out.
//
// Input channel: link_byte with in_valid / in_stall; one byte accepted per request.
// Frame format: 0x0A, 16-bit big-endian length, payload bytes, 0xA0.
// Output channel: kind, payload_byte, last_payload, status, frame_length with
// out_valid / out_stall. Each byte yields zero or one result: start and length
// bytes yield none unless in error.
// Throughput: one byte per cycle, sustained, when the receiver does not stall.
// Path: each accepted byte is held in the input register; its result is then held
// in the result register until it is taken.
// Stall: a result waits in the output register; one more byte is taken into
// the input register, and then in_stall rises until the result is taken.
// Bytes that give no result pass through even while the output is stalled.
// Config: max_payload at address 0, reset 4096; write only when the parser is idle.
// Reset: asynchronous, active low; parser hunts for a start byte, nothing pending.
module start_length_end_frame_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [slef_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     link_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     kind,
    output logic [7:0]                     payload_byte,
    output logic                           last_payload,
    output logic [1:0]                     status,
    output logic [15:0]                    frame_length
);
    import slef_pkg::*;

    logic [15:0] max_payload;
    logic        out_free;
    logic        res_load;
    slef_res_t   res;
    slef_res_t   out_res;

    slef_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_payload (max_payload)
    );

    slef_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .link_byte   (link_byte),
        .max_payload (max_payload),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res)
    );

    slef_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign kind         = out_res.kind;
    assign payload_byte = out_res.payload_byte;
    assign last_payload = out_res.last_payload;
    assign status       = out_res.status;
    assign frame_length = out_res.frame_length;

endmodule

// ===== rtl/core/slef_cfg.sv =====
// APB-style configuration register block: holds max_payload.
// Depends on slef_pkg.
module slef_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [slef_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [15:0]                    max_payload
);
    import slef_pkg::*;

    logic [15:0] max_payload_reg;
    logic [15:0] max_payload_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_MAX_PAYLOAD);

    always_comb
    begin
        max_payload_next = max_payload_reg;
        if (wr_en)
        begin
            max_payload_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RST;
        end
        else
        begin
            max_payload_reg <= max_payload_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_MAX_PAYLOAD)
        begin
            prdata = {16'd0, max_payload_reg};
        end
    end

    assign max_payload = max_payload_reg;

endmodule

// ===== rtl/core/slef_parse.sv =====
// Input register and frame state machine; forms one result per byte at most.
// Depends on slef_pkg and the assertion macro header.
`include "start_length_end_frame_parser_macros.svh"

module slef_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          link_byte,
    input  logic [15:0]         max_payload,
    input  logic                out_free,
    output logic                res_load,
    output slef_pkg::slef_res_t res
);
    import slef_pkg::*;

    logic        in_vld_reg;
    logic        in_vld_next;
    logic [7:0]  byte_reg;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] length_reg;
    logic [15:0] length_next;
    logic [15:0] remaining_reg;
    logic [15:0] remaining_next;
    logic        produce;
    logic        adv;
    logic        accept;
    logic [15:0] full_len;

    assign full_len = {length_reg[15:8], byte_reg};

    // next state and result for the byte held in the input register
    always_comb
    begin
        phase_next     = phase_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        produce        = 1'b0;
        res            = '{kind: KIND_ERROR, payload_byte: 8'd0, last_payload: 1'b0,
                           status: ST_OK, frame_length: length_reg};
        case (phase_reg)
            PH_LEN_HI:
            begin
                length_next = {byte_reg, 8'd0};
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next = full_len;
                if (full_len > max_payload)
                begin
                    phase_next       = PH_HUNT;
                    produce          = 1'b1;
                    res.status       = ST_TOO_LONG;
                    res.frame_length = full_len;
                end
                else
                begin
                    remaining_next = full_len;
                    phase_next     = (full_len == 16'd0) ? PH_END : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                produce          = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = byte_reg;
                res.last_payload = (remaining_reg <= 16'd1);
                if (remaining_reg <= 16'd1)
                begin
                    remaining_next = 16'd0;
                    phase_next     = PH_END;
                end
                else
                begin
                    remaining_next = remaining_reg - 16'd1;
                end
            end
            PH_END:
            begin
                phase_next = PH_HUNT;
                produce    = 1'b1;
                if (byte_reg == END_MARK)
                begin
                    res.kind = KIND_END;
                end
                else
                begin
                    res.status = ST_BAD_END;
                end
            end
            default:
            begin
                // hunting; unused codes behave the same
                phase_next = PH_HUNT;
                if (byte_reg == START_MARK)
                begin
                    length_next    = 16'd0;
                    remaining_next = 16'd0;
                    phase_next     = PH_LEN_HI;
                end
                else
                begin
                    produce          = 1'b1;
                    res.status       = ST_BAD_START;
                    res.frame_length = 16'd0;
                end
            end
        endcase
    end

    // a byte that yields no result never waits on the output side
    assign adv      = in_vld_reg && (!produce || out_free);
    assign res_load = adv && produce;
    assign in_stall = in_vld_reg && !adv;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (adv)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            phase_reg     <= PH_HUNT;
            length_reg    <= 16'd0;
            remaining_reg <= 16'd0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (adv)
            begin
                phase_reg     <= phase_next;
                length_reg    <= length_next;
                remaining_reg <= remaining_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= link_byte;
        end
    end

    `SLEF_ASSERT_NOW(a_payload_count_nonzero, phase_reg == PH_PAYLOAD, remaining_reg != 16'd0)
    `SLEF_ASSERT_NOW(a_payload_count_bound, phase_reg == PH_PAYLOAD, remaining_reg <= length_reg)
    `SLEF_ASSERT_NEXT(a_last_goes_to_end,
        adv && phase_reg == PH_PAYLOAD && remaining_reg <= 16'd1, phase_reg == PH_END)
    `SLEF_ASSERT_NOW(a_stall_only_when_held, in_stall, in_vld_reg && produce && !out_free)

endmodule

// ===== rtl/core/slef_out.sv =====
// Output register for parser results, held while the receiver stalls.
// Depends on slef_pkg.
module slef_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_load,
    input  slef_pkg::slef_res_t res,
    output logic                out_free,
    output logic                out_valid,
    input  logic                out_stall,
    output slef_pkg::slef_res_t out_res
);
    import slef_pkg::*;

    logic      out_vld_reg;
    logic      out_vld_next;
    slef_res_t res_reg;

    assign out_free = !out_vld_reg || !out_stall;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (res_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_res   = res_reg;

endmodule
